/* design/sdks_pkg.sv */
// Shared types and constants for the stable descending key sort.
package sdks_pkg;
  localparam int unsigned MaxEntries = 1024;
  localparam int unsigned KeyBits    = 32;
  localparam int unsigned IdxBits    = $clog2(MaxEntries);
  localparam int unsigned CntBits    = IdxBits + 1;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_PULL = 1'b1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RANK_RD,
    ST_RANK_CMP,
    ST_RANK_WR,
    ST_EMIT_RD,
    ST_EMIT_KEY,
    ST_EMIT_DONE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic push;
    logic rank_start;
    logic rank_load_k;
    logic rank_step;
    logic rank_write;
    logic emit_key;
    logic emit_empty;
    logic emit_done;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic none_left;
    logic scan_done;
    logic rank_done;
    logic is_last;
  } sts_t;
endpackage

/* design/sdks_datapath.sv */
// Datapath: key and order memories, ranking counters and output word.
module sdks_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sdks_pkg::cmd_t                cmd,
  output sdks_pkg::sts_t                sts,
  input  logic [31:0]                   in_key,
  output logic [sdks_pkg::IdxBits-1:0]  o_idx,
  output logic [31:0]                   o_key,
  output logic                          o_last,
  output logic                          o_empty,
  output logic                          o_ovf
);
  localparam int unsigned IB = sdks_pkg::IdxBits;
  localparam int unsigned CB = sdks_pkg::CntBits;

  logic [sdks_pkg::KeyBits-1:0] key_mem [sdks_pkg::MaxEntries];
  logic [IB-1:0]                ord_mem [sdks_pkg::MaxEntries];

  logic [CB-1:0] count_r, rptr_r, i_r, j_r, pos_r;
  logic          ovf_r;
  logic [sdks_pkg::KeyBits-1:0] k_r, rd_key_r;
  logic [IB-1:0] rd_ord_r;
  logic [IB-1:0] key_raddr;

  always_comb begin
    key_raddr = j_r[IB-1:0];
    if (cmd.rank_start) key_raddr = '0;
    else if (cmd.rank_load_k) key_raddr = '0;
    else if (cmd.rank_step) key_raddr = j_r[IB-1:0] + 1'b1;
    else if (cmd.emit_key) key_raddr = rd_ord_r;
    else if (cmd.rank_write) key_raddr = i_r[IB-1:0] + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !(count_r == CB'(sdks_pkg::MaxEntries)))
      key_mem[count_r[IB-1:0]] <= in_key[sdks_pkg::KeyBits-1:0];
    rd_key_r <= key_mem[key_raddr];
    if (cmd.rank_write) ord_mem[pos_r[IB-1:0]] <= i_r[IB-1:0];
    rd_ord_r <= ord_mem[rptr_r[IB-1:0]];
  end

  // rank: k = key[i]; pos = count of j with key[j]>k or (== and j<i)
  logic gt;
  assign gt = (rd_key_r > k_r) || (rd_key_r == k_r && j_r < i_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0; rptr_r <= '0; ovf_r <= 1'b0;
      i_r <= '0; j_r <= '0; pos_r <= '0;
    end else begin
      if (cmd.push) begin
        if (count_r == CB'(sdks_pkg::MaxEntries)) ovf_r <= 1'b1;
        else count_r <= count_r + 1'b1;
      end
      if (cmd.rank_start) i_r <= '0;
      if (cmd.rank_load_k) begin
        k_r <= rd_key_r; j_r <= '0; pos_r <= '0;
      end
      if (cmd.rank_step) begin
        pos_r <= pos_r + CB'(gt);
        j_r <= j_r + 1'b1;
      end
      if (cmd.rank_write) i_r <= i_r + 1'b1;
      if (cmd.emit_key) rptr_r <= rptr_r + 1'b1;
      if (cmd.clear) begin
        count_r <= '0; rptr_r <= '0; ovf_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_empty) begin
      o_idx <= '0; o_key <= '0; o_last <= 1'b0; o_empty <= 1'b1; o_ovf <= ovf_r;
    end else if (cmd.emit_key) begin
      o_idx <= rd_ord_r; o_empty <= 1'b0; o_ovf <= ovf_r;
      o_last <= (rptr_r + 1'b1 == count_r);
    end
    if (cmd.emit_done) o_key <= 32'(rd_key_r);
  end

  assign sts.none_left = (count_r == '0) || (rptr_r >= count_r);
  assign sts.scan_done = (j_r + 1'b1 == count_r);
  assign sts.rank_done = (i_r + 1'b1 == count_r);
  assign sts.is_last   = o_last;
endmodule

/* design/sdks_ctrl.sv */
// Controller: sequences loading, ranking and unloading.
module sdks_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_func,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output sdks_pkg::cmd_t cmd,
  input  sdks_pkg::sts_t sts
);
  sdks_pkg::state_t state_r, state_nxt;
  logic sorted_r, sorted_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sdks_pkg::ST_LOAD; sorted_r <= 1'b0;
    end else begin
      state_r <= state_nxt; sorted_r <= sorted_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sorted_nxt = sorted_r;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      sdks_pkg::ST_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_func == sdks_pkg::FUNC_PUSH) begin
            cmd.push = !sorted_r;
          end else if (sts.none_left) begin
            cmd.emit_empty = 1'b1;
            state_nxt = sdks_pkg::ST_OUT;
          end else if (!sorted_r) begin
            cmd.rank_start = 1'b1;
            state_nxt = sdks_pkg::ST_RANK_RD;
          end else begin
            state_nxt = sdks_pkg::ST_EMIT_RD;
          end
        end
      end
      sdks_pkg::ST_RANK_RD: begin
        cmd.rank_load_k = 1'b1;
        state_nxt = sdks_pkg::ST_RANK_CMP;
      end
      sdks_pkg::ST_RANK_CMP: begin
        cmd.rank_step = 1'b1;
        if (sts.scan_done) state_nxt = sdks_pkg::ST_RANK_WR;
      end
      sdks_pkg::ST_RANK_WR: begin
        cmd.rank_write = 1'b1;
        if (sts.rank_done) begin
          sorted_nxt = 1'b1;
          state_nxt = sdks_pkg::ST_EMIT_RD;
        end else begin
          state_nxt = sdks_pkg::ST_RANK_RD;
        end
      end
      sdks_pkg::ST_EMIT_RD: state_nxt = sdks_pkg::ST_EMIT_KEY;
      sdks_pkg::ST_EMIT_KEY: begin
        cmd.emit_key = 1'b1;
        state_nxt = sdks_pkg::ST_EMIT_DONE;
      end
      sdks_pkg::ST_EMIT_DONE: begin
        cmd.emit_done = 1'b1;
        state_nxt = sdks_pkg::ST_OUT;
      end
      sdks_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = sdks_pkg::ST_LOAD;
          if (sts.is_last) begin
            cmd.clear = 1'b1;
            sorted_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = sdks_pkg::ST_LOAD;
    endcase
  end
endmodule

/* design/stable_descending_key_sort.sv */
// Top level of the stable descending key sort.
// Usage:
//  in_ channel: in_func 0 pushes in_key_value, 1 pulls the next sorted word.
//  out_ channel: one word per pull with arrival index, key and flags.
//  A push is taken in the load state without a stall; pushes while unloading are dropped.
//  The first pull of a batch ranks all n stored keys through the key memory
//  read port, each by a scan over all n keys; the word then follows through
//  the emit read, key and done states, which later pulls pass through alone.
//  An empty pull answers in the cycle after it is taken, with empty flag set.
//  While out_valid is high and out_stall holds, the word stays unchanged and
//  in_stall stays high; one item is in flight at a time.
//  The pull that returns the last entry clears the batch on handoff.
//  Reset (synchronous, rst_n low) empties the store; memories are not
//  cleared, so no clearing pass is needed.
module stable_descending_key_sort (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [31:0] in_key_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  out_arrival_index,
  output logic [31:0] out_sorted_key,
  output logic        out_last_flag,
  output logic        out_empty_flag,
  output logic        out_overflow_flag
);
  sdks_pkg::cmd_t cmd;
  sdks_pkg::sts_t sts;

  sdks_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_func, .in_stall, .out_valid, .out_stall,
    .cmd, .sts
  );

  sdks_datapath u_dp (
    .clk, .rst_n, .cmd, .sts, .in_key(in_key_value),
    .o_idx(out_arrival_index), .o_key(out_sorted_key), .o_last(out_last_flag),
    .o_empty(out_empty_flag), .o_ovf(out_overflow_flag)
  );

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open during output");
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_last_flag && out_empty_flag)) else $error("last and empty");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("word dropped");
`endif
endmodule

/* tb/sdks_checker.sv */
// Checker for the stable descending key sort: predicts and compares output words.
module sdks_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_func,
  input  logic [31:0] in_key_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [9:0]  out_arrival_index,
  input  logic [31:0] out_sorted_key,
  input  logic        out_last_flag,
  input  logic        out_empty_flag,
  input  logic        out_overflow_flag,
  output int          fail_count,
  output int          pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ExpDepth = 4;

  typedef struct packed {
    logic [sdks_pkg::IdxBits-1:0] idx;
    logic [sdks_pkg::KeyBits-1:0] key;
    logic                         last;
    logic                         empty;
    logic                         ovf;
  } sorted_word_t;

  logic [sdks_pkg::KeyBits-1:0] batch_keys [sdks_pkg::MaxEntries];
  logic [sdks_pkg::IdxBits-1:0] rank_order [sdks_pkg::MaxEntries];
  int unsigned        batch_len;
  int unsigned        emit_pos;
  logic               ranked;
  logic               dropped;
  sorted_word_t       exp_words [ExpDepth];
  logic [1:0]         exp_wr;
  logic [1:0]         exp_rd;
  int                 exp_cnt;

  assign pending_words = exp_cnt;

  task automatic rank_batch();
    int unsigned pos;
    logic [sdks_pkg::KeyBits-1:0] ki;
    logic [sdks_pkg::KeyBits-1:0] kj;
    for (int unsigned i = 0; i < batch_len; i++) begin
      pos = 0;
      ki = batch_keys[i[sdks_pkg::IdxBits-1:0]];
      for (int unsigned j = 0; j < batch_len; j++) begin
        kj = batch_keys[j[sdks_pkg::IdxBits-1:0]];
        if (kj > ki || (kj == ki && j < i)) begin
          pos++;
        end
      end
      rank_order[pos[sdks_pkg::IdxBits-1:0]] = i[sdks_pkg::IdxBits-1:0];
    end
    ranked = 1'b1;
  endtask

  task automatic store_expected(input sorted_word_t w);
    if (exp_cnt == ExpDepth) begin
      $error("expected word buffer overrun");
      fail_count++;
      return;
    end
    exp_words[exp_wr] = w;
    exp_wr++;
    exp_cnt++;
  endtask

  task automatic predict(input logic func, input logic [sdks_pkg::KeyBits-1:0] key);
    sorted_word_t w;
    w = '0;
    w.ovf = dropped;
    if (func == sdks_pkg::FUNC_PUSH) begin
      if (ranked) begin
        return;
      end
      if (batch_len >= sdks_pkg::MaxEntries) begin
        dropped = 1'b1;
      end else begin
        batch_keys[batch_len[sdks_pkg::IdxBits-1:0]] = key;
        batch_len++;
      end
      return;
    end
    if (batch_len == 0 || emit_pos >= batch_len) begin
      w.empty = 1'b1;
      store_expected(w);
      return;
    end
    if (!ranked) begin
      rank_batch();
    end
    w.idx = rank_order[emit_pos[sdks_pkg::IdxBits-1:0]];
    w.key = batch_keys[w.idx];
    emit_pos++;
    if (emit_pos >= batch_len) begin
      w.last    = 1'b1;
      batch_len = 0;
      emit_pos  = 0;
      ranked    = 1'b0;
      dropped   = 1'b0;
    end
    store_expected(w);
  endtask

  task automatic compare_word();
    sorted_word_t w;
    if (exp_cnt == 0) begin
      $error("unexpected output word");
      fail_count++;
      return;
    end
    w = exp_words[exp_rd];
    exp_rd++;
    exp_cnt--;
    if (out_arrival_index !== w.idx) begin
      $error("arrival_index expected %0d got %0d", w.idx, out_arrival_index);
      fail_count++;
    end
    if (out_sorted_key !== w.key) begin
      $error("sorted_key expected %h got %h", w.key, out_sorted_key);
      fail_count++;
    end
    if (out_last_flag !== w.last) begin
      $error("last_flag expected %b got %b", w.last, out_last_flag);
      fail_count++;
    end
    if (out_empty_flag !== w.empty) begin
      $error("empty_flag expected %b got %b", w.empty, out_empty_flag);
      fail_count++;
    end
    if (out_overflow_flag !== w.ovf) begin
      $error("overflow_flag expected %b got %b", w.ovf, out_overflow_flag);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fail_count = 0;
      batch_len  = 0;
      emit_pos   = 0;
      ranked     = 1'b0;
      dropped    = 1'b0;
      exp_wr     = '0;
      exp_rd     = '0;
      exp_cnt    = 0;
    end else begin
      if (out_valid && !out_stall) begin
        compare_word();
      end
      if (in_valid && !in_stall) begin
        predict(in_func, in_key_value);
      end
    end
  end
endmodule

/* tb/tb_stable_descending_key_sort.sv */
// Testbench top for the stable descending key sort: stimulus and verdict.
module tb_stable_descending_key_sort;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   CYCLE_LIMIT = 4000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_func = sdks_pkg::FUNC_PUSH;
  logic [31:0] in_key_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [9:0]  out_arrival_index;
  logic [31:0] out_sorted_key;
  logic        out_last_flag;
  logic        out_empty_flag;
  logic        out_overflow_flag;
  int          fail_count;
  int          pending_words;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stable_descending_key_sort uut (.*);

  sdks_checker u_checker (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: stall mode rotates through none, light and heavy random stalls, plus one long hold-off
  always @(posedge clk) begin
    int mode;
    mode = (cycle_count / 64) % 4;
    if (cycle_count >= 2000 && cycle_count < 2400) begin
      out_stall <= 1'b1;
    end else if (mode == 0) begin
      out_stall <= 1'b0;
    end else if (mode == 1) begin
      out_stall <= ($urandom_range(0, 9) < 3);
    end else begin
      out_stall <= ($urandom_range(0, 9) < 7);
    end
  end

  function automatic logic [31:0] rand_key();
    case ($urandom_range(0, 3))
      0: rand_key = $urandom();
      1: rand_key = $urandom_range(0, 7);
      2: rand_key = {2'($urandom_range(0, 3)), 30'h3fff_fff0} | 32'($urandom_range(0, 15));
      default: rand_key = ($urandom_range(0, 1) != 0) ? 32'hffff_ffff : 32'h0;
    endcase
  endfunction

  task automatic send_word(input logic func, input logic [31:0] key);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 15);
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_func      <= func;
    in_key_value <= key;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic run_batch(input int n);
    for (int i = 0; i < n; i++) begin
      send_word(sdks_pkg::FUNC_PUSH, rand_key());
    end
    for (int i = 0; i < n; i++) begin
      send_word(sdks_pkg::FUNC_PULL, rand_key());
      if ($urandom_range(0, 9) == 0) begin
        send_word(sdks_pkg::FUNC_PUSH, rand_key());
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      send_word(sdks_pkg::FUNC_PULL, rand_key());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pull, extremes, ties, push while unloading, single entry
    send_word(sdks_pkg::FUNC_PULL, 32'h0);
    send_word(sdks_pkg::FUNC_PUSH, 32'h0);
    send_word(sdks_pkg::FUNC_PUSH, 32'hffff_ffff);
    send_word(sdks_pkg::FUNC_PUSH, 32'hffff_ffff);
    send_word(sdks_pkg::FUNC_PUSH, 32'h0);
    send_word(sdks_pkg::FUNC_PUSH, 32'h8000_0000);
    send_word(sdks_pkg::FUNC_PULL, 32'hffff_ffff);
    send_word(sdks_pkg::FUNC_PUSH, 32'h1234_5678);
    for (int i = 0; i < 4; i++) begin
      send_word(sdks_pkg::FUNC_PULL, 32'h0);
    end
    send_word(sdks_pkg::FUNC_PULL, 32'h0);
    send_word(sdks_pkg::FUNC_PUSH, 32'h0000_0001);
    send_word(sdks_pkg::FUNC_PULL, 32'h0);
    send_word(sdks_pkg::FUNC_PULL, 32'h0);

    sent = 0;
    while (sent < 760) begin
      run_batch(($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12));
    end

    // drain leftovers, fill the store, overflow it, then pull a few words
    for (int i = 0; i < 48; i++) begin
      send_word(sdks_pkg::FUNC_PULL, 32'h0);
    end
    for (int i = 0; i < 1027; i++) begin
      send_word(sdks_pkg::FUNC_PUSH,
                ($urandom_range(0, 1) != 0) ? $urandom_range(0, 50) : $urandom());
    end
    for (int i = 0; i < 24; i++) begin
      send_word(sdks_pkg::FUNC_PULL, 32'h0);
    end
    in_valid <= 1'b0;

    while (pending_words != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
